### src/esc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for epoch seconds to calendar
// Commands and status between controller and datapath, calendar constants.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int unsigned SecsW   = 32;
    localparam int unsigned DaysW   = 16;
    localparam int unsigned TodW    = 17;

    // Day count by reciprocal: 86400 = 128 * 675, so drop 7 bits first and
    // multiply the 25-bit remainder by ceil(2^35 / 675)
    localparam int unsigned DayPre     = 7;
    localparam int unsigned DayNumW    = SecsW - DayPre;
    localparam int unsigned DayRecipW  = 26;
    localparam int unsigned DayShift   = 35;
    localparam logic [DayRecipW-1:0] DAY_RECIP = 26'd50903317;

    // Days by 7 via ceil(2^19 / 7), exact for any 16-bit day count
    localparam int unsigned WeekRecipW = 17;
    localparam int unsigned WeekShift  = 19;
    localparam logic [WeekRecipW-1:0] WEEK_RECIP = 17'd74899;

    localparam logic [TodW:0]   SECS_PER_DAY  = 18'd86400;
    localparam logic [TodW-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [TodW-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [11:0]     EPOCH_YEAR    = 12'd1970;
    localparam logic [8:0]      DAYS_COMMON   = 9'd365;
    localparam logic [8:0]      DAYS_LEAP     = 9'd366;
    localparam logic [2:0]      EPOCH_WEEKDAY = 3'd4;
    localparam logic [3:0]      LAST_MONTH    = 4'd11;

    // Year counters start at 1970 reduced by 4, 100 and 400
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rem_step;
        logic cal_step;
        logic mon_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic time_done;
        logic mon_done;
    } t_status;

    // Days in month, month counted from 0
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd1:                        len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

### src/esc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_datapath: calendar arithmetic
// Reciprocal day division, year/time-of-day subtraction, month subtraction
// and the output register.
// ----------------------------------------------------------------------------
module esc_datapath
    import esc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cmd              i_cmd,
    output t_status                o_sts,
    input  wire logic [SecsW-1:0]  i_seconds_count,
    output logic [11:0]            o_year,
    output logic [3:0]             o_month,
    output logic [4:0]             o_day_of_month,
    output logic [4:0]             o_hour,
    output logic [5:0]             o_minute,
    output logic [5:0]             o_second,
    output logic [2:0]             o_weekday
);

    logic [SecsW-1:0] r_dividend;
    logic [TodW-1:0]  r_rem;      // seconds of day
    logic [DaysW-1:0] r_quot;     // whole days, then remaining days
    logic [2:0]       r_wk;       // days mod 7
    logic [11:0]      r_year;
    logic [1:0]       r_mod4;
    logic [6:0]       r_mod100;
    logic [8:0]       r_mod400;
    logic [3:0]       r_mon;
    logic [4:0]       r_hour;
    logic [5:0]       r_min;

    logic [DayNumW+DayRecipW-1:0] day_prod;
    logic [SecsW-1:0]             tod_back;
    logic [DaysW+WeekRecipW-1:0]  wk_prod;
    logic             leap;
    logic [8:0]       year_len;
    logic [4:0]       mon_len;
    logic [3:0]       wk_sum;

    assign day_prod = {{DayRecipW{1'b0}}, r_dividend[SecsW-1:DayPre]} *
                      {{DayNumW{1'b0}}, DAY_RECIP};
    assign tod_back = {{(SecsW-DaysW){1'b0}}, r_quot} *
                      {{(SecsW-TodW-1){1'b0}}, SECS_PER_DAY};
    assign wk_prod  = {{WeekRecipW{1'b0}}, r_quot} * {{DaysW{1'b0}}, WEEK_RECIP};
    assign leap     = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mon_len  = month_len(r_mon, leap);
    assign wk_sum   = {1'b0, r_wk} + {1'b0, EPOCH_WEEKDAY};

    assign o_sts.year_done = (r_quot < {{(DaysW-9){1'b0}}, year_len});
    assign o_sts.time_done = (r_rem < SECS_PER_MIN);
    assign o_sts.mon_done  = (r_mon == LAST_MONTH) ||
                             (r_quot < {{(DaysW-5){1'b0}}, mon_len});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dividend <= i_seconds_count;
            r_rem      <= '0;
            r_quot     <= '0;
            r_wk       <= '0;
            r_year     <= EPOCH_YEAR;
            r_mod4     <= EPOCH_MOD4;
            r_mod100   <= EPOCH_MOD100;
            r_mod400   <= EPOCH_MOD400;
            r_mon      <= '0;
            r_hour     <= '0;
            r_min      <= '0;
        end
        if (i_cmd.div_step) begin
            r_quot <= day_prod[DayShift +: DaysW];
        end
        if (i_cmd.rem_step) begin
            r_rem <= TodW'(r_dividend - tod_back);
            // days - 7q keeps its low bits as days + q, since -7 is 1 mod 8
            r_wk  <= r_quot[2:0] + wk_prod[WeekShift +: 3];
        end
        if (i_cmd.cal_step) begin
            // advance one whole year
            if (!o_sts.year_done) begin
                r_quot   <= r_quot - {{(DaysW-9){1'b0}}, year_len};
                r_year   <= r_year + 12'd1;
                r_mod4   <= r_mod4 + 2'd1;
                r_mod100 <= (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
                r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
            end
            // hours first, then minutes, from the seconds of day
            if (r_rem >= SECS_PER_HOUR) begin
                r_rem  <= r_rem - SECS_PER_HOUR;
                r_hour <= r_hour + 5'd1;
            end else if (!o_sts.time_done) begin
                r_rem  <= r_rem - SECS_PER_MIN;
                r_min  <= r_min + 6'd1;
            end
        end
        if (i_cmd.mon_step && !o_sts.mon_done) begin
            r_quot <= r_quot - {{(DaysW-5){1'b0}}, mon_len};
            r_mon  <= r_mon + 4'd1;
        end
        if (i_cmd.out_load) begin
            o_year         <= r_year;
            o_month        <= r_mon + 4'd1;
            o_day_of_month <= r_quot[4:0] + 5'd1;
            o_hour         <= r_hour;
            o_minute       <= r_min;
            o_second       <= r_rem[5:0];
            o_weekday      <= (wk_sum >= 4'd7) ? 3'(wk_sum - 4'd7) : wk_sum[2:0];
        end
    end

endmodule
`default_nettype wire

### src/esc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_ctrl: sequencing controller
// Steps the datapath through division, year/time and month phases and
// runs both handshakes.
// ----------------------------------------------------------------------------
module esc_ctrl
    import esc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_cmd         o_cmd,
    input  wire t_status i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REM,
        S_CAL,
        S_MON,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_REM;
            end
            S_REM: begin
                o_cmd.rem_step = 1'b1;
                n_state        = S_CAL;
            end
            S_CAL: begin
                o_cmd.cal_step = 1'b1;
                if (i_sts.year_done && i_sts.time_done) begin
                    n_state = S_MON;
                end
            end
            S_MON: begin
                o_cmd.mon_step = 1'b1;
                if (i_sts.mon_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DIV))
        else $error("accepted item did not start division");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("output register overwritten while stalled");

    a_mon_after_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MON) |-> (i_sts.year_done && i_sts.time_done))
        else $error("month phase entered before year and time finished");
`endif

endmodule
`default_nettype wire

### src/epoch_seconds_to_calendar.sv
`default_nettype none
// From acceptance to result valid: a quotient step, a remainder step, then a
// combined phase that counts off elapsed years and hours/minutes together
// until both are done, then the month steps and finally the output load.
// One item at a time: a new item is taken only once the previous result is
// loaded. A stalled result holds the next one in its final state.
// Reset (synchronous, active low) clears the controller and output valid.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to Gregorian date and time
// Controller and datapath; result held in an output register.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_seconds_count,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day_of_month,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    output logic [2:0]       o_weekday
);

    t_cmd    cmd;
    t_status sts;

    esc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    esc_datapath u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_seconds_count (i_seconds_count),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday)
    );

endmodule
`default_nettype wire
